// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/suwi_pkg.sv =====
// package for the sorted unique word store: sizes, types and helpers
package suwi_pkg;

  localparam int WORD_CHARS  = 16;
  localparam int STORE_DEPTH = 256;

  localparam int CHAR_W     = 8;
  localparam int LEN_W      = $clog2(WORD_CHARS + 1);
  localparam int CNT_W      = $clog2(STORE_DEPTH + 1);
  localparam int POSITION_W = 8;
  localparam int COUNT_W    = 9;

  // byte 0 is the most significant, so a plain compare is lexicographic
  typedef logic [0:WORD_CHARS-1][CHAR_W-1:0] word_t;
  typedef logic [LEN_W-1:0]                  len_t;
  typedef logic [CNT_W-1:0]                  cnt_t;

  typedef struct packed {
    logic compare_en;
    logic insert_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic hit;
    logic eq;
  } cell_flags_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CHAR_W'("A") && c <= CHAR_W'("Z")) begin
      r = c + CHAR_W'(8'h20);
    end
    return r;
  endfunction

endpackage

// ===== src/suwi_char_if.sv =====
// byte channel: one byte of a word and its final-byte flag
interface suwi_char_if;
  import suwi_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== src/suwi_result_if.sv =====
// result channel: one record per word
interface suwi_result_if;
  import suwi_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [POSITION_W-1:0] position;
  logic                  was_present;
  logic [COUNT_W-1:0]    word_count;
  logic                  store_full;
  logic                  truncated;

  modport source (output valid, output position, output was_present, output word_count,
                  output store_full, output truncated, input ready);
  modport sink   (input valid, input position, input was_present, input word_count,
                  input store_full, input truncated, output ready);
endinterface

// ===== src/suwi_cell.sv =====
// one store cell: holds a word, compares it and shifts on insertion
module suwi_cell import suwi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cnt_t        cell_index,
  input  cnt_t        count,
  input  cell_ctrl_t  ctrl,
  input  word_t       new_word,
  input  len_t        new_len,
  input  word_t       left_word,
  input  len_t        left_len,
  input  logic        left_lt,
  output word_t       word,
  output len_t        len,
  output logic        lt,
  output cell_flags_t flags
);

  logic eq;
  logic occupied;
  logic lt_next;
  logic eq_next;

  // padded bytes are zero on both sides, so length only breaks a tie
  assign occupied = cell_index < count;
  assign lt_next  = occupied && ((word < new_word) || (word == new_word && len < new_len));
  assign eq_next  = occupied && (word == new_word) && (len == new_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (ctrl.compare_en) begin
      lt <= lt_next;
      eq <= eq_next;
    end
  end

  // first cell not below the word takes it, the ones above take their left neighbour
  always_ff @(posedge clk) begin
    if (ctrl.insert_en && !lt) begin
      if (left_lt) begin
        word <= new_word;
        len  <= new_len;
      end else begin
        word <= left_word;
        len  <= left_len;
      end
    end
  end

  assign flags.hit = !lt && left_lt;
  assign flags.eq  = eq;

endmodule

// ===== src/sorted_unique_word_insert.sv =====
// Sorted unique word store, top level
//
// chars carries a word one byte per transfer, last_char set on its final byte.
// Letters A-Z are folded to lower case; bytes past WORD_CHARS are dropped and
// the word is flagged truncated. results carries one record per word: the
// position where it was inserted or found, whether it was present, the count
// of distinct words, and the full and truncated flags.
// A byte that is not final is only written into the byte buffer. A final byte
// starts the word's steps: transfer, a compare in every cell of the chain, a
// one-hot resolve of the insertion point, and the shift of the cells above it,
// which also loads the result register and waits while the previous result is held.
// chars.ready is low while a word is in flight.
// The result sits in an output register: the next word's bytes are taken
// while it waits, and only the update step of the next word waits for it.
// Reset empties the store and the byte buffer at once; no clearing pass.
module sorted_unique_word_insert import suwi_pkg::*; (
  input logic           clk,
  input logic           rst,
  suwi_char_if.sink     chars,
  suwi_result_if.source results
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_FIND  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]  state;
  logic [1:0]  state_next;
  word_t       buffer;
  word_t       buffer_next;
  len_t        length;
  len_t        length_next;
  logic        overflow;
  logic        overflow_next;
  cnt_t        count;
  cnt_t        count_next;
  logic        found;
  cnt_t        pos;
  logic        found_sel;
  logic        hit_any;
  cnt_t        pos_sel;
  logic        accept;
  logic        apply_go;
  logic        insert;
  logic        full;
  cell_ctrl_t  ctrl;

  logic                  out_valid;
  logic [POSITION_W-1:0] out_position;
  logic                  out_present;
  logic [COUNT_W-1:0]    out_count;
  logic                  out_full;
  logic                  out_trunc;

  word_t       chain_word [0:STORE_DEPTH];
  len_t        chain_len  [0:STORE_DEPTH];
  logic        chain_lt   [0:STORE_DEPTH];
  cell_flags_t flags      [0:STORE_DEPTH-1];

  assign chars.ready = (state == S_IDLE);
  assign accept      = chars.valid && chars.ready;
  assign apply_go    = !out_valid || results.ready;
  assign insert      = !found && (count != CNT_W'(STORE_DEPTH));
  assign full        = !found && (count == CNT_W'(STORE_DEPTH));

  assign ctrl.compare_en = (state == S_CMP);
  assign ctrl.insert_en  = (state == S_APPLY) && apply_go && insert;

  // byte buffer
  always_comb begin
    buffer_next   = buffer;
    length_next   = length;
    overflow_next = overflow;
    if (accept) begin
      if (length < LEN_W'(WORD_CHARS)) begin
        for (int j = 0; j < WORD_CHARS; j++) begin
          if (length == LEN_W'(j)) begin
            buffer_next[j] = fold_case(chars.char_code);
          end
        end
        length_next = length + LEN_W'(1);
      end else begin
        overflow_next = 1'b1;
      end
    end else if (state == S_APPLY && apply_go) begin
      buffer_next   = '0;
      length_next   = '0;
      overflow_next = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && chars.last_char) state_next = S_CMP;
      S_CMP:   state_next = S_FIND;
      S_FIND:  state_next = S_APPLY;
      S_APPLY: if (apply_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // only one cell marks the boundary; none does when every cell holds a smaller word
  always_comb begin
    pos_sel   = '0;
    hit_any   = 1'b0;
    found_sel = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (flags[i].hit) begin
        pos_sel   = pos_sel | CNT_W'(i);
        hit_any   = 1'b1;
        found_sel = found_sel | flags[i].eq;
      end
    end
    if (!hit_any) begin
      pos_sel = CNT_W'(STORE_DEPTH);
    end
  end

  assign count_next = count + CNT_W'(insert);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      buffer    <= '0;
      length    <= '0;
      overflow  <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      buffer   <= buffer_next;
      length   <= length_next;
      overflow <= overflow_next;
      if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_APPLY && apply_go) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIND) begin
      found <= found_sel;
      pos   <= pos_sel;
    end
    if (state == S_APPLY && apply_go) begin
      out_position <= full ? '0 : POSITION_W'(pos);
      out_present  <= found;
      out_count    <= COUNT_W'(count_next);
      out_full     <= full;
      out_trunc    <= overflow;
    end
  end

  assign chain_word[0] = buffer;
  assign chain_len[0]  = length;
  assign chain_lt[0]   = 1'b1;

  for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
    suwi_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (CNT_W'(g)),
      .count      (count),
      .ctrl       (ctrl),
      .new_word   (buffer),
      .new_len    (length),
      .left_word  (chain_word[g]),
      .left_len   (chain_len[g]),
      .left_lt    (chain_lt[g]),
      .word       (chain_word[g+1]),
      .len        (chain_len[g+1]),
      .lt         (chain_lt[g+1]),
      .flags      (flags[g])
    );
  end

  assign results.valid       = out_valid;
  assign results.position    = out_position;
  assign results.was_present = out_present;
  assign results.word_count  = out_count;
  assign results.store_full  = out_full;
  assign results.truncated   = out_trunc;

endmodule

// ===== src/suwi_checker.sv =====
// port-level checker for the word store, bound to the top level
`include "assert_macros.svh"

module suwi_checker import suwi_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  chars_valid,
  input logic                  chars_ready,
  input logic                  chars_last_char,
  input logic                  results_valid,
  input logic                  results_ready,
  input logic [POSITION_W-1:0] results_position,
  input logic                  results_was_present,
  input logic [COUNT_W-1:0]    results_word_count,
  input logic                  results_store_full
);

  // reset empties the result register
  `ASSERT_CLK_ALWAYS(a_reset_clears_result, clk, rst |=> !results_valid, "result valid after reset")

  // a stalled result keeps its count
  `ASSERT_CLK(a_result_hold, clk, rst, results_valid && !results_ready |=> results_valid && $stable(results_word_count), "stalled result changed")

  // a dropped word reports position zero and not present
  `ASSERT_CLK(a_full_fields, clk, rst, results_valid && results_store_full |-> results_position == '0 && !results_was_present, "dropped word fields wrong")

  // a fresh result follows a final byte that was taken earlier
  `ASSERT_CLK(a_result_source, clk, rst, $rose(results_valid) |-> $past(chars_valid && chars_ready && chars_last_char, 4), "result without final byte")

  // no byte is taken while a word is in flight
  `ASSERT_CLK(a_busy_after_last, clk, rst, chars_valid && chars_ready && chars_last_char |=> !chars_ready, "byte taken while busy")

endmodule

bind sorted_unique_word_insert suwi_checker u_suwi_checker (
  .clk                 (clk),
  .rst                 (rst),
  .chars_valid         (chars.valid),
  .chars_ready         (chars.ready),
  .chars_last_char     (chars.last_char),
  .results_valid       (results.valid),
  .results_ready       (results.ready),
  .results_position    (results.position),
  .results_was_present (results.was_present),
  .results_word_count  (results.word_count),
  .results_store_full  (results.store_full)
);

// ===== tb/testbench.sv =====
// testbench for the sorted unique word store: streams words, predicts each record, checks them
module testbench import suwi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [POSITION_W-1:0] position;
    logic                  was_present;
    logic [COUNT_W-1:0]    word_count;
    logic                  store_full;
    logic                  truncated;
  } word_record_t;

  // predicts the store and holds the records still owed by the block
  class word_store_board;
    word_t        entries [STORE_DEPTH];
    int unsigned  entry_len [STORE_DEPTH];
    int unsigned  entry_count;
    word_t        held_word;
    int unsigned  held_len;
    bit           overflowed;
    word_record_t pending_records [$];
    int           errors;

    function new();
      entry_count = 0;
      held_word   = '0;
      held_len    = 0;
      overflowed  = 0;
      errors      = 0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // lexicographic order of the held word against entry e, shorter prefix first
    function int order_vs(input int unsigned e);
      int unsigned m;
      m = (held_len < entry_len[e]) ? held_len : entry_len[e];
      for (int unsigned i = 0; i < m; i++) begin
        if (held_word[i] != entries[e][i]) begin
          return (held_word[i] < entries[e][i]) ? -1 : 1;
        end
      end
      if (held_len == entry_len[e]) return 0;
      return (held_len < entry_len[e]) ? -1 : 1;
    endfunction

    function void note_byte(input logic [CHAR_W-1:0] c, input logic last);
      logic [CHAR_W-1:0] folded;
      int unsigned       pos;
      bit                found;
      int                r;
      word_record_t      rec;
      folded = c;
      if (c >= "A" && c <= "Z") folded = c + 8'h20;
      if (held_len < WORD_CHARS) begin
        held_word[held_len] = folded;
        held_len++;
      end else begin
        overflowed = 1;
      end
      if (!last) return;

      pos   = entry_count;
      found = 0;
      for (int unsigned i = 0; i < entry_count; i++) begin
        r = order_vs(i);
        if (r <= 0) begin
          pos   = i;
          found = (r == 0);
          break;
        end
      end

      rec = '0;
      if (!found) begin
        if (entry_count >= STORE_DEPTH) begin
          rec.store_full = 1;
          pos = 0;
        end else begin
          for (int unsigned j = entry_count; j > pos; j--) begin
            entries[j]   = entries[j-1];
            entry_len[j] = entry_len[j-1];
          end
          entries[pos]   = held_word;
          entry_len[pos] = held_len;
          entry_count++;
        end
      end
      rec.position    = pos[POSITION_W-1:0];
      rec.was_present = found;
      rec.word_count  = entry_count[COUNT_W-1:0];
      rec.truncated   = overflowed;
      pending_records.push_back(rec);

      held_word  = '0;
      held_len   = 0;
      overflowed = 0;
    endfunction

    task check_record(input word_record_t got);
      word_record_t want;
      if (pending_records.size() == 0) begin
        report("record arrived with none outstanding");
        return;
      end
      want = pending_records.pop_front();
      if (got.position !== want.position)
        report($sformatf("position %0d, want %0d", got.position, want.position));
      if (got.was_present !== want.was_present)
        report($sformatf("was_present %0b, want %0b", got.was_present, want.was_present));
      if (got.word_count !== want.word_count)
        report($sformatf("word_count %0d, want %0d", got.word_count, want.word_count));
      if (got.store_full !== want.store_full)
        report($sformatf("store_full %0b, want %0b", got.store_full, want.store_full));
      if (got.truncated !== want.truncated)
        report($sformatf("truncated %0b, want %0b", got.truncated, want.truncated));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  suwi_char_if   chars_if ();
  suwi_result_if results_if ();

  sorted_unique_word_insert dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  word_store_board   sb;
  bit                calm;
  int unsigned       bytes_sent;
  logic [CHAR_W-1:0] word_bytes [$];
  word_t             history_word [$];
  int unsigned       history_len [$];

  function automatic logic [CHAR_W-1:0] rand_byte();
    if ($urandom_range(1) == 1) begin
      return ($urandom_range(1) == 1 ? 8'h41 : 8'h61) + 8'($urandom_range(25));
    end
    return 8'($urandom_range(1, 255));
  endfunction

  // one byte per transfer, with random gaps unless calm
  task automatic send_word();
    int unsigned idle;
    word_t       w;
    int unsigned n;
    w = '0;
    n = 0;
    for (int i = 0; i < word_bytes.size(); i++) begin
      idle = calm ? 0 : 17;
      while ($urandom_range(99) < idle) begin
        chars_if.valid <= 1'b0;
        @(posedge clk);
      end
      chars_if.valid     <= 1'b1;
      chars_if.char_code <= word_bytes[i];
      chars_if.last_char <= (i == word_bytes.size() - 1);
      do @(posedge clk); while (!chars_if.ready);
      sb.note_byte(word_bytes[i], i == word_bytes.size() - 1);
      bytes_sent++;
      if (n < WORD_CHARS) begin
        w[n] = word_bytes[i];
        n++;
      end
    end
    history_word.push_back(w);
    history_len.push_back(n);
  endtask

  task automatic make_fresh(input int unsigned len);
    word_bytes.delete();
    repeat (len) word_bytes.push_back(rand_byte());
  endtask

  // replay an earlier word with its case flipped at random, cut short or lengthened
  task automatic reuse_word(input bit as_prefix);
    int unsigned       idx;
    int unsigned       len;
    logic [CHAR_W-1:0] c;
    idx = $urandom_range(history_word.size() - 1);
    len = history_len[idx];
    if (as_prefix && $urandom_range(1) == 1) len = $urandom_range(1, len);
    word_bytes.delete();
    for (int unsigned i = 0; i < len; i++) begin
      c = history_word[idx][i];
      if ($urandom_range(1) == 1) begin
        if (c >= "a" && c <= "z") c = c - 8'h20;
        else if (c >= "A" && c <= "Z") c = c + 8'h20;
      end
      word_bytes.push_back(c);
    end
    if (as_prefix && len == history_len[idx]) word_bytes.push_back(rand_byte());
    if (!as_prefix && len == WORD_CHARS && $urandom_range(1) == 1) begin
      repeat ($urandom_range(1, 4)) word_bytes.push_back(rand_byte());
    end
  endtask

  // result side: check the transfer, then choose ready for the next edge
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      sb.check_record('{position:    results_if.position,
                        was_present: results_if.was_present,
                        word_count:  results_if.word_count,
                        store_full:  results_if.store_full,
                        truncated:   results_if.truncated});
    end
    results_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
  end

  initial begin
    int unsigned words;
    int unsigned after_full;
    int unsigned pick;
    sb                  = new();
    calm                = 0;
    bytes_sent          = 0;
    rst                 <= 1'b1;
    chars_if.valid      <= 1'b0;
    chars_if.char_code  <= '0;
    chars_if.last_char  <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // byte extremes, case folding and its neighbours, then an overlong word
    word_bytes = {8'h01};         send_word();
    word_bytes = {8'hFF};         send_word();
    word_bytes = {8'h41};         send_word();
    word_bytes = {8'h61};         send_word();
    word_bytes = {8'h5A};         send_word();
    word_bytes = {8'h40};         send_word();
    word_bytes = {8'h5B};         send_word();
    word_bytes = {8'h60};         send_word();
    word_bytes = {8'h7B};         send_word();
    word_bytes.delete();
    repeat (16) word_bytes.push_back(8'h51);
    word_bytes.push_back(8'h78);
    send_word();

    // mostly short fresh words so the store fills within the byte budget
    words      = 0;
    after_full = 0;
    while (bytes_sent < 1300 || after_full < 40) begin
      calm = (words >= 60 && words < 140);
      pick = $urandom_range(99);
      if (pick < 70) begin
        pick = $urandom_range(99);
        if (pick < 85)      make_fresh($urandom_range(1, 3));
        else if (pick < 97) make_fresh($urandom_range(4, 16));
        else                make_fresh($urandom_range(17, 24));
      end else if (pick < 85) begin
        reuse_word(1'b0);
      end else begin
        reuse_word(1'b1);
      end
      send_word();
      words++;
      if (sb.entry_count >= STORE_DEPTH) after_full++;
    end
    calm = 0;
    chars_if.valid <= 1'b0;

    while (sb.pending_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_records.size() == 0) begin
      $display("[sorted_unique_word_insert] OK");
    end else begin
      $display("[sorted_unique_word_insert] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[sorted_unique_word_insert] ERROR");
    $finish;
  end

endmodule
